// ===== sv/mst_pkg.sv =====
package mst_pkg;

	localparam int VTX_W = 6;
	localparam int CNT_W = 6;
	localparam int VC_W = 7;
	localparam int SUM_W = 22;
	localparam logic [VC_W-1:0] VC_RESET = 7'd64;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_SCAN_INIT,
		ST_SCAN,
		ST_PICK,
		ST_RD_A,
		ST_RD_B,
		ST_CMP,
		ST_SWEEP,
		ST_OUT_RD,
		ST_OUT_LD,
		ST_OUT_HOLD
	} mst_state_t;

endpackage

// ===== sv/minimum_spanning_tree_kruskal_top.sv =====
// Load: one cycle per edge word.
// Run: each edge visited in weight order costs one scan of all n stored edges plus a label
// lookup of both endpoints; each accepted edge adds a relabel sweep over all MAX_VERTICES labels.
// Output: each result word is held until the sink takes it; no input taken during run.
// Reset (arst_n low) clears control state and sets vertex_count to 64; label table reads as
// identity through per-vertex valid bits, no clearing pass.
module minimum_spanning_tree_kruskal_top
	import mst_pkg::*;
#(
	parameter int MAX_VERTICES = 64,
	parameter int MAX_EDGES = 256,
	parameter int WEIGHT_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [VC_W-1:0]               cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          carries_edge,
	input  logic [VTX_W-1:0]              from_vertex,
	input  logic [VTX_W-1:0]              to_vertex,
	input  logic signed [WEIGHT_BITS-1:0] weight,
	input  logic                          last_edge,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [VTX_W-1:0]              tree_from,
	output logic [VTX_W-1:0]              tree_to,
	output logic signed [WEIGHT_BITS-1:0] tree_weight,
	output logic                          edge_valid,
	output logic                          last_result,
	output logic signed [SUM_W-1:0]       total_weight,
	output logic [CNT_W-1:0]              tree_edge_count,
	output logic                          input_dropped
);

	localparam int EW = 2 * VTX_W + WEIGHT_BITS;
	localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int CW = $clog2(MAX_EDGES + 1);
	localparam int LAW = $clog2(MAX_VERTICES);
	localparam int TDEPTH = MAX_VERTICES - 1;
	localparam int TAW = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;
	localparam int ACC_W = ((WEIGHT_BITS > SUM_W) ? WEIGHT_BITS : SUM_W) + 1;
	localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(2097151);
	localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-2097152);

	mst_state_t state_q, state_d;

	logic [VC_W-1:0] vc_q;
	logic [VC_W-1:0] nv;
	logic [CW-1:0] cnt_q, i_q, j_q;
	logic [EAW-1:0] j_s1;
	logic rd_v_s1;
	logic [CNT_W-1:0] acc_q, kout_q;
	logic signed [SUM_W-1:0] sum_q;
	logic drop_q;

	logic have_prev_q, found_q;
	logic signed [WEIGHT_BITS-1:0] prev_w_q, best_w_q;
	logic [EAW-1:0] prev_idx_q, best_idx_q;
	logic [VTX_W-1:0] best_from_q, best_to_q;

	logic [MAX_VERTICES-1:0] lvalid_q;
	logic [VTX_W-1:0] la_q, lb_q;
	logic [LAW:0] k_q;
	logic [LAW-1:0] k_s1;
	logic sv_s1;

	logic e_we;
	logic [EAW-1:0] e_raddr;
	logic [EW-1:0] e_rdata;
	logic [VTX_W-1:0] e_from, e_to;
	logic signed [WEIGHT_BITS-1:0] e_w;

	logic l_we;
	logic [LAW-1:0] l_raddr;
	logic [VTX_W-1:0] l_rdata;
	logic [LAW-1:0] l_raddr_s1;
	logic [VTX_W-1:0] l_eff;

	logic t_we;
	logic [EW-1:0] t_rdata;

	logic in_acc, in_ok, scan_done, stop_run, cand, better, out_last;
	logic signed [ACC_W-1:0] sum_ext;
	logic signed [SUM_W-1:0] sum_sat;

	always_comb begin
		if (vc_q == '0) begin
			nv = VC_W'(1);
		end else if (vc_q > VC_W'(MAX_VERTICES)) begin
			nv = VC_W'(MAX_VERTICES);
		end else begin
			nv = vc_q;
		end
	end

	assign in_acc = in_valid && !in_stall;
	assign in_ok = carries_edge && (VC_W'(from_vertex) < nv) && (VC_W'(to_vertex) < nv)
		&& (cnt_q < CW'(MAX_EDGES));
	assign scan_done = (j_q == cnt_q) && !rd_v_s1;
	assign stop_run = (i_q == cnt_q) || ((VC_W'(acc_q) + VC_W'(1)) >= nv);
	assign out_last = (acc_q == '0) || (kout_q + CNT_W'(1) == acc_q);

	assign e_from = e_rdata[EW-1 -: VTX_W];
	assign e_to = e_rdata[WEIGHT_BITS +: VTX_W];
	assign e_w = e_rdata[WEIGHT_BITS-1:0];

	assign cand = !have_prev_q || (e_w > prev_w_q) || ((e_w == prev_w_q) && (j_s1 > prev_idx_q));
	assign better = !found_q || (e_w < best_w_q) || ((e_w == best_w_q) && (j_s1 < best_idx_q));

	assign l_eff = lvalid_q[l_raddr_s1] ? l_rdata : VTX_W'(l_raddr_s1);

	assign sum_ext = ACC_W'(sum_q) + ACC_W'(best_w_q);
	always_comb begin
		if (sum_ext > SAT_HI) begin
			sum_sat = SUM_W'(SAT_HI);
		end else if (sum_ext < SAT_LO) begin
			sum_sat = SUM_W'(SAT_LO);
		end else begin
			sum_sat = SUM_W'(sum_ext);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (in_acc && last_edge) state_d = ST_SCAN_INIT;
			end
			ST_SCAN_INIT: begin
				state_d = stop_run ? ST_OUT_RD : ST_SCAN;
			end
			ST_SCAN: begin
				if (scan_done) state_d = ST_PICK;
			end
			ST_PICK: begin
				if ((VC_W'(best_from_q) >= nv) || (VC_W'(best_to_q) >= nv)) begin
					state_d = ST_SCAN_INIT;
				end else begin
					state_d = ST_RD_A;
				end
			end
			ST_RD_A: state_d = ST_RD_B;
			ST_RD_B: state_d = ST_CMP;
			ST_CMP: begin
				state_d = (la_q != l_eff) ? ST_SWEEP : ST_SCAN_INIT;
			end
			ST_SWEEP: begin
				if ((k_q == (LAW+1)'(MAX_VERTICES)) && !sv_s1) state_d = ST_SCAN_INIT;
			end
			ST_OUT_RD: state_d = ST_OUT_LD;
			ST_OUT_LD: state_d = ST_OUT_HOLD;
			ST_OUT_HOLD: begin
				if (!out_stall) state_d = last_result ? ST_LOAD : ST_OUT_RD;
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		out_valid = 1'b0;
		e_we = 1'b0;
		e_raddr = j_q[EAW-1:0];
		l_we = 1'b0;
		l_raddr = k_q[LAW-1:0];
		t_we = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				in_stall = 1'b0;
				e_we = in_acc && in_ok;
			end
			ST_RD_A: l_raddr = best_from_q[LAW-1:0];
			ST_RD_B: l_raddr = best_to_q[LAW-1:0];
			ST_CMP: t_we = (la_q != l_eff);
			ST_SWEEP: l_we = sv_s1 && (l_eff == lb_q);
			ST_OUT_HOLD: out_valid = 1'b1;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			vc_q <= VC_RESET;
			cnt_q <= '0;
			i_q <= '0;
			j_q <= '0;
			rd_v_s1 <= 1'b0;
			acc_q <= '0;
			kout_q <= '0;
			sum_q <= '0;
			drop_q <= 1'b0;
			have_prev_q <= 1'b0;
			found_q <= 1'b0;
			lvalid_q <= '0;
			k_q <= '0;
			sv_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) vc_q <= cfg_wr_data;
			rd_v_s1 <= (state_q == ST_SCAN) && (j_q != cnt_q);
			sv_s1 <= (state_q == ST_SWEEP) && (k_q != (LAW+1)'(MAX_VERTICES));
			unique case (state_q)
				ST_LOAD: begin
					if (in_acc && carries_edge) begin
						if (in_ok) cnt_q <= cnt_q + CW'(1);
						else drop_q <= 1'b1;
					end
				end
				ST_SCAN_INIT: begin
					j_q <= '0;
					found_q <= 1'b0;
					kout_q <= '0;
				end
				ST_SCAN: begin
					if (j_q != cnt_q) j_q <= j_q + CW'(1);
					if (rd_v_s1 && cand && better) found_q <= 1'b1;
				end
				ST_PICK: begin
					if ((VC_W'(best_from_q) >= nv) || (VC_W'(best_to_q) >= nv)) begin
						drop_q <= 1'b1;
						i_q <= i_q + CW'(1);
						have_prev_q <= 1'b1;
					end
				end
				ST_CMP: begin
					i_q <= i_q + CW'(1);
					have_prev_q <= 1'b1;
					k_q <= '0;
					if (la_q != l_eff) begin
						acc_q <= acc_q + CNT_W'(1);
						sum_q <= sum_sat;
					end
				end
				ST_SWEEP: begin
					if (k_q != (LAW+1)'(MAX_VERTICES)) k_q <= k_q + (LAW+1)'(1);
					if (l_we) lvalid_q[k_s1] <= 1'b1;
				end
				ST_OUT_HOLD: begin
					if (!out_stall) begin
						kout_q <= kout_q + CNT_W'(1);
						if (last_result) begin
							cnt_q <= '0;
							i_q <= '0;
							acc_q <= '0;
							sum_q <= '0;
							drop_q <= 1'b0;
							have_prev_q <= 1'b0;
							lvalid_q <= '0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		j_s1 <= j_q[EAW-1:0];
		k_s1 <= k_q[LAW-1:0];
		l_raddr_s1 <= l_raddr;
		if (state_q == ST_SCAN && rd_v_s1 && cand && better) begin
			best_w_q <= e_w;
			best_idx_q <= j_s1;
			best_from_q <= e_from;
			best_to_q <= e_to;
		end
		if (state_q == ST_PICK || state_q == ST_CMP) begin
			prev_w_q <= best_w_q;
			prev_idx_q <= best_idx_q;
		end
		if (state_q == ST_RD_B) la_q <= l_eff;
		if (state_q == ST_CMP) lb_q <= l_eff;
		if (state_q == ST_OUT_LD) begin
			edge_valid <= (acc_q != '0);
			last_result <= out_last;
			input_dropped <= drop_q;
			total_weight <= out_last ? sum_q : '0;
			tree_edge_count <= out_last ? acc_q : '0;
			if (acc_q != '0) begin
				tree_from <= t_rdata[EW-1 -: VTX_W];
				tree_to <= t_rdata[WEIGHT_BITS +: VTX_W];
				tree_weight <= t_rdata[WEIGHT_BITS-1:0];
			end else begin
				tree_from <= '0;
				tree_to <= '0;
				tree_weight <= '0;
			end
		end
	end

	mst_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_EDGES),
		.AW(EAW)
	) u_edge_ram (
		.clk(clk),
		.we(e_we),
		.waddr(cnt_q[EAW-1:0]),
		.wdata({from_vertex, to_vertex, weight}),
		.raddr(e_raddr),
		.rdata(e_rdata)
	);

	mst_ram #(
		.WIDTH(VTX_W),
		.DEPTH(MAX_VERTICES),
		.AW(LAW)
	) u_label_ram (
		.clk(clk),
		.we(l_we),
		.waddr(k_s1),
		.wdata(la_q),
		.raddr(l_raddr),
		.rdata(l_rdata)
	);

	mst_ram #(
		.WIDTH(EW),
		.DEPTH(TDEPTH),
		.AW(TAW)
	) u_tree_ram (
		.clk(clk),
		.we(t_we),
		.waddr(acc_q[TAW-1:0]),
		.wdata({best_from_q, best_to_q, best_w_q}),
		.raddr(kout_q[TAW-1:0]),
		.rdata(t_rdata)
	);

endmodule

// ===== sv/mst_ram.sv =====
module mst_ram
	import mst_pkg::*;
#(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	parameter int AW = 2
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
